// File: rtl/core/lwpi_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the looped waypoint path interpolator.
// No dependencies; imported by the top level.
package lwpi_pkg;

    localparam int COORD_W = 32;
    localparam int TIME_W  = 48;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PREPARE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNPREP    = 2'd1,
        STATUS_ZERO_LOOP = 2'd2
    } status_t;

    localparam logic REG_SPEED = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_LATB,
        ST_P_SQ,
        ST_P_ACC,
        ST_P_SQRT,
        ST_P_LEN,
        ST_P_DLD,
        ST_P_DIV,
        ST_P_QUO,
        ST_P_WR,
        ST_Q_MOD,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_MUL,
        ST_Q_DLD,
        ST_Q_DIV,
        ST_Q_ADD,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/lwpi_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lwpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/looped_waypoint_path_interpolator.sv
`timescale 1ns / 1ps
// Looped waypoint path interpolator: top level with sequencer and shared datapath.
// Depends on lwpi_pkg and lwpi_ram.
//
// Usage: items enter on the s_ channel; the kind of item (load, prepare, query,
// no-op) travels in s_tuser. Every item gives exactly one result on the m_
// channel, positions in m_tdata and status in m_tuser. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. One item is worked
// at a time; s_tready is high only while the sequencer idles. Load and no-op
// go straight to the result. Prepare spends most of its time per waypoint in
// the 32-step square root and the (32+FRAC_BITS)-step divide. Query runs a
// 48-step modulo, walks the segments up to the one holding the time, then
// runs three 64-step divides, all on the one shared restoring divider.
// Reset clears the sequencer, loop time and prepared flag and sets speed to
// 1.0; the waypoint and duration RAMs hold garbage until written.
// The finished result sits in an output register; a stalled receiver holds it
// there, and the next item is accepted and worked meanwhile, waiting only to
// hand its own result over.
module looped_waypoint_path_interpolator #(
    parameter int MAX_WAYPOINTS = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,  // waypoint_index, coord_x, coord_y, coord_z, query_time, pad
    input  logic [1:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // pos_x, pos_y, pos_z
    output logic [1:0]   m_tuser,  // status
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import lwpi_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [8:0] MAX9 = 9'(MAX_WAYPOINTS);
    localparam logic [6:0] PREP_ITERS = 7'(32 + FRAC_BITS);
    localparam logic [6:0] MOD_ITERS  = 7'(TIME_W);
    localparam logic [6:0] STEP_ITERS = 7'd64;

    state_t state_reg, state_next;

    logic [31:0]     speed_reg;
    logic [4:0]      count_reg;
    logic [TIME_W-1:0] loop_reg;
    logic            prepared_reg;
    logic [CW-1:0]   active_reg;
    logic [CW-1:0]   seg_reg;
    logic [1:0]      k_reg;
    op_t             op_reg;

    logic [95:0]     a_reg, b_reg;
    logic [63:0]     prod_reg;
    logic [63:0]     sum_reg;
    logic            ovf_reg;
    logic [31:0]     len_reg;
    logic [31:0]     dur_reg;
    logic [TIME_W-1:0] total_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] start_reg;
    logic [31:0]     elapsed_reg;
    logic [95:0]     pos_reg;
    status_t         status_reg;

    logic [63:0]     sq_rad_reg;
    logic [33:0]     sq_rem_reg;
    logic [31:0]     sq_root_reg;

    logic [63:0]     div_num_reg;
    logic [TIME_W-1:0] div_den_reg;
    logic [TIME_W-1:0] div_rem_reg;
    logic [6:0]      cnt_reg;

    logic            m_tvalid_reg;
    logic [95:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    // item fields
    op_t             in_op;
    logic [3:0]      in_idx;
    logic [95:0]     in_xyz;
    logic [TIME_W-1:0] in_qt;
    logic            accept;
    logic [8:0]      in_idx9;
    logic            idx_ok;
    logic [8:0]      cnt9;
    logic [8:0]      n9;
    logic [CW-1:0]   n_clamped;

    assign in_op   = op_t'(s_tuser);
    assign in_idx  = s_tdata[3:0];
    assign in_xyz  = s_tdata[99:4];
    assign in_qt   = s_tdata[147:100];
    assign accept  = s_tvalid && s_tready;
    assign in_idx9 = {5'd0, in_idx};
    assign idx_ok  = in_idx9 < MAX9;
    assign cnt9    = {4'd0, count_reg};
    assign n9      = (cnt9 > MAX9) ? MAX9 : cnt9;
    assign n_clamped = n9[CW-1:0];

    // segment index and its successor around the loop
    logic [CW-1:0] seg_inc, seg_nxt;
    assign seg_inc = seg_reg + CW'(1);
    assign seg_nxt = (seg_inc == active_reg) ? '0 : seg_inc;

    // axis difference b - a and its magnitude
    logic [31:0] a_ax, b_ax;
    logic [32:0] diff;
    logic [32:0] diff_neg;
    logic [31:0] mag;
    logic        neg;
    assign a_ax     = a_reg[32*k_reg +: 32];
    assign b_ax     = b_reg[32*k_reg +: 32];
    assign diff     = {b_ax[31], b_ax} - {a_ax[31], a_ax};
    assign diff_neg = 33'd0 - diff;
    assign neg      = diff[32];
    assign mag      = neg ? diff_neg[31:0] : diff[31:0];

    // shared multiplier
    logic [31:0] mul_b;
    logic [63:0] mul_out;
    assign mul_b   = (state_reg == ST_P_SQ) ? mag : elapsed_reg;
    assign mul_out = 64'(mag) * 64'(mul_b);

    logic [64:0] acc_sum;
    assign acc_sum = {1'b0, sum_reg} + {1'b0, prod_reg};

    // one restoring divide step
    logic [TIME_W:0] div_rem_s;
    logic            div_ge;
    logic [TIME_W:0] div_diff;
    assign div_rem_s = {div_rem_reg, div_num_reg[63]};
    assign div_ge    = div_rem_s >= {1'b0, div_den_reg};
    assign div_diff  = div_rem_s - {1'b0, div_den_reg};

    // one square-root digit step
    logic [33:0] sq_rem_s, sq_trial;
    logic        sq_ge;
    assign sq_rem_s = {sq_rem_reg[31:0], sq_rad_reg[63:62]};
    assign sq_trial = {sq_root_reg, 2'b01};
    assign sq_ge    = sq_rem_s >= sq_trial;

    // walk compare
    logic [TIME_W-1:0] walk_end;
    logic [TIME_W-1:0] elapsed_full;
    logic [31:0]       dur_rd;
    assign walk_end     = start_reg + TIME_W'(dur_rd);
    assign elapsed_full = t_reg - start_reg;

    logic [31:0] step_q;
    logic [31:0] pos_ax;
    assign step_q = div_num_reg[31:0];
    assign pos_ax = neg ? (a_ax - step_q) : (a_ax + step_q);

    logic [TIME_W-1:0] total_sum;
    assign total_sum = total_reg + TIME_W'(dur_reg);

    // RAM control
    logic          wp_we, dur_we;
    logic [AW-1:0] wp_waddr, wp_raddr, dur_addr;
    logic [95:0]   wp_rd;

    always_comb
    begin
        wp_we    = accept && (in_op == OP_LOAD) && idx_ok;
        wp_waddr = in_idx9[AW-1:0];
        wp_raddr = (state_reg == ST_RDB) ? seg_nxt[AW-1:0] : seg_reg[AW-1:0];
        dur_we   = (state_reg == ST_P_WR);
        dur_addr = seg_reg[AW-1:0];
    end

    lwpi_ram #(.WIDTH(96), .DEPTH(MAX_WAYPOINTS)) u_wp_ram (
        .clk   (clk),
        .we    (wp_we),
        .waddr (wp_waddr),
        .wdata (in_xyz),
        .raddr (wp_raddr),
        .rdata (wp_rd)
    );

    lwpi_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (dur_addr),
        .wdata (dur_reg),
        .raddr (dur_addr),
        .rdata (dur_rd)
    );

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_PREPARE: state_next = (n_clamped == '0) ? ST_DONE : ST_RDA;
                        OP_QUERY:
                        begin
                            if (!prepared_reg || loop_reg == '0 || active_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_Q_MOD;
                            end
                        end
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_RDA:    state_next = ST_RDB;
            ST_RDB:    state_next = ST_LATB;
            ST_LATB:   state_next = (op_reg == OP_PREPARE) ? ST_P_SQ : ST_Q_MUL;
            ST_P_SQ:   state_next = ST_P_ACC;
            ST_P_ACC:
            begin
                if (k_reg != 2'd2)
                begin
                    state_next = ST_P_SQ;
                end
                else if (ovf_reg || acc_sum[64])
                begin
                    state_next = ST_P_DLD;
                end
                else
                begin
                    state_next = ST_P_SQRT;
                end
            end
            ST_P_SQRT: state_next = (cnt_reg == 7'd1) ? ST_P_LEN : ST_P_SQRT;
            ST_P_LEN:  state_next = ST_P_DLD;
            ST_P_DLD:
            begin
                if (len_reg == '0 || speed_reg == '0)
                begin
                    state_next = ST_P_WR;
                end
                else
                begin
                    state_next = ST_P_DIV;
                end
            end
            ST_P_DIV:  state_next = (cnt_reg == 7'd1) ? ST_P_QUO : ST_P_DIV;
            ST_P_QUO:  state_next = ST_P_WR;
            ST_P_WR:   state_next = (seg_inc == active_reg) ? ST_DONE : ST_RDA;
            ST_Q_MOD:  state_next = (cnt_reg == 7'd1) ? ST_Q_RD : ST_Q_MOD;
            ST_Q_RD:   state_next = ST_Q_CHK;
            ST_Q_CHK:  state_next = (walk_end > t_reg) ? ST_RDA : ST_Q_RD;
            ST_Q_MUL:  state_next = ST_Q_DLD;
            ST_Q_DLD:  state_next = ST_Q_DIV;
            ST_Q_DIV:  state_next = (cnt_reg == 7'd1) ? ST_Q_ADD : ST_Q_DIV;
            ST_Q_ADD:  state_next = (k_reg == 2'd2) ? ST_DONE : ST_Q_MUL;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
        m_tuser  = m_tuser_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            speed_reg    <= 32'd65536;
            count_reg    <= '0;
            loop_reg     <= '0;
            prepared_reg <= 1'b0;
            active_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_SPEED)
                begin
                    speed_reg <= cfg_data;
                end
                else
                begin
                    count_reg <= cfg_data[4:0];
                end
            end
            if (accept && in_op == OP_LOAD && idx_ok)
            begin
                prepared_reg <= 1'b0;
            end
            if (accept && in_op == OP_PREPARE)
            begin
                active_reg <= n_clamped;
                if (n_clamped == '0)
                begin
                    loop_reg     <= '0;
                    prepared_reg <= 1'b1;
                end
            end
            if (state_reg == ST_P_WR && seg_inc == active_reg)
            begin
                loop_reg     <= total_sum;
                prepared_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg     <= in_op;
                seg_reg    <= '0;
                total_reg  <= '0;
                start_reg  <= '0;
                pos_reg    <= '0;
                status_reg <= STATUS_OK;
                if (!prepared_reg)
                begin
                    status_reg <= STATUS_UNPREP;
                end
                else if (loop_reg == '0 || active_reg == '0)
                begin
                    status_reg <= STATUS_ZERO_LOOP;
                end
                if (in_op != OP_QUERY)
                begin
                    status_reg <= STATUS_OK;
                end
                // reduce the time modulo the loop
                div_num_reg <= {in_qt, 16'd0};
                div_den_reg <= loop_reg;
                div_rem_reg <= '0;
                cnt_reg     <= MOD_ITERS;
            end
            ST_RDB:
            begin
                a_reg <= wp_rd;
                k_reg <= '0;
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            ST_LATB:
            begin
                b_reg <= wp_rd;
            end
            ST_P_SQ, ST_Q_MUL:
            begin
                prod_reg <= mul_out;
            end
            ST_P_ACC:
            begin
                sum_reg <= acc_sum[63:0];
                ovf_reg <= ovf_reg | acc_sum[64];
                k_reg   <= k_reg + 2'd1;
                len_reg <= 32'hFFFF_FFFF;
                sq_rad_reg  <= acc_sum[63:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                cnt_reg     <= 7'd32;
            end
            ST_P_SQRT:
            begin
                sq_rad_reg <= {sq_rad_reg[61:0], 2'b00};
                if (sq_ge)
                begin
                    sq_rem_reg  <= sq_rem_s - sq_trial;
                    sq_root_reg <= {sq_root_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= sq_rem_s;
                    sq_root_reg <= {sq_root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
            end
            ST_P_LEN:
            begin
                len_reg <= sq_root_reg;
            end
            ST_P_DLD:
            begin
                dur_reg     <= (len_reg == '0) ? 32'd0 : 32'hFFFF_FFFF;
                div_num_reg <= {len_reg, 32'd0};
                div_den_reg <= {16'd0, speed_reg};
                div_rem_reg <= '0;
                cnt_reg     <= PREP_ITERS;
            end
            ST_P_DIV, ST_Q_MOD, ST_Q_DIV:
            begin
                div_num_reg <= {div_num_reg[62:0], div_ge};
                div_rem_reg <= div_ge ? div_diff[TIME_W-1:0] : div_rem_s[TIME_W-1:0];
                cnt_reg     <= cnt_reg - 7'd1;
                if (state_reg == ST_Q_MOD && cnt_reg == 7'd1)
                begin
                    t_reg <= div_ge ? div_diff[TIME_W-1:0] : div_rem_s[TIME_W-1:0];
                end
            end
            ST_P_QUO:
            begin
                // saturate quotients past 32 bits
                dur_reg <= (div_num_reg[63:32] != '0) ? 32'hFFFF_FFFF : div_num_reg[31:0];
            end
            ST_P_WR:
            begin
                total_reg <= total_sum;
                seg_reg   <= seg_inc;
            end
            ST_Q_CHK:
            begin
                if (walk_end > t_reg)
                begin
                    dur_reg     <= dur_rd;
                    elapsed_reg <= elapsed_full[31:0];
                end
                else
                begin
                    start_reg <= walk_end;
                    seg_reg   <= seg_inc;
                end
            end
            ST_Q_DLD:
            begin
                div_num_reg <= prod_reg;
                div_den_reg <= {16'd0, dur_reg};
                div_rem_reg <= '0;
                cnt_reg     <= STEP_ITERS;
            end
            ST_Q_ADD:
            begin
                pos_reg[32*k_reg +: 32] <= pos_ax;
                k_reg <= k_reg + 2'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= pos_reg;
                    m_tuser_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_LOAD && idx_ok) |=> !prepared_reg)
        else $error("prepared flag survived a waypoint load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_CHK) |-> (seg_reg < active_reg))
        else $error("segment walk ran past the active segments");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_DIV || state_reg == ST_Q_MOD || state_reg == ST_Q_DIV)
        |-> (div_rem_reg < div_den_reg))
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (state_reg != ST_IDLE || m_tvalid_reg))
        else $error("pending result dropped");

endmodule
